// ===== design/bit_pattern_frequency_counter_top_defines.svh =====
// Assertion macros for the bit pattern frequency counter.
// Included by the top level; no other dependencies.
`ifndef BIT_PATTERN_FREQUENCY_COUNTER_TOP_DEFINES_SVH
`define BIT_PATTERN_FREQUENCY_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define BPFC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpfc assertion failed");
// Next-cycle implication, disabled while reset is high.
`define BPFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpfc assertion failed");
`else
`define BPFC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BPFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/bpfc_pkg.sv =====
// Shared constants, types and helper functions of the bit pattern frequency counter.
// No dependencies; used by bpfc_cell and the top level.
`timescale 1ns / 1ps

package bpfc_pkg;

   localparam int LONGEST_PATTERN = 12;
   localparam int COUNT_BITS      = 20;
   localparam int LEN_BITS        = 4;
   localparam int ADDR_BITS       = LONGEST_PATTERN;
   localparam int PATTERN_SPACE   = 1 << ADDR_BITS;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Transaction action codes.
   localparam logic ACTION_SHIFT = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH = 2'd1;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                 lookup;
      logic                 shift;
      logic                 update;
      logic                 clear;
      logic [ADDR_BITS-1:0] clear_addr;
   } cell_ctrl_type;

   // Mask that keeps the low len bits of a pattern.
   function automatic logic [ADDR_BITS-1:0] low_mask(input logic [LEN_BITS-1:0] len);
      logic [ADDR_BITS-1:0] mask;
      for (int j = 0; j < ADDR_BITS; j++) begin
         mask[j] = (j < 32'(len));
      end
      return mask;
   endfunction

endpackage

// ===== design/bit_pattern_frequency_counter_top.sv =====
// Top level of the bit pattern frequency counter: sequencer, configuration registers,
// output register and the chain of bpfc_cell instances. Depends on bpfc_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "bit_pattern_frequency_counter_top_defines.svh"

// The block counts how often each bit pattern of length min_length..max_length
// appears in a serial bit stream, with patterns taken oldest bit first. A request
// transaction with action 0 shifts one stream bit in; one with action 1 reads the
// saturating 20-bit count of query_pattern at query_length and returns it as a
// response transaction. Shift transactions produce no response. The design is a
// chain of twelve cells, one per pattern length: each holds one bit of the window,
// a flag telling whether that bit has arrived, and a single-port bank of 4096
// counters. The acceptance cycle reads the counters; the update state that follows
// writes the incremented counters back, or for a read loads the response register.
// That read-modify-write of the counter banks means a new transaction is taken only
// once the block is back in the idle state. A read also waits in the update state
// while a previous response is still stalled in the output register. After reset a
// clearing pass zeroes all banks in parallel, one address per cycle, during which
// req_stall stays high. Configuration writes are accepted at any time but should only
// be made while the block is idle.
module bit_pattern_frequency_counter_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_action,
   input  logic                                     req_stream_bit,
   input  logic [bpfc_pkg::LEN_BITS-1:0]            req_query_length,
   input  logic [bpfc_pkg::ADDR_BITS-1:0]           req_query_pattern,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [bpfc_pkg::COUNT_BITS-1:0]          rsp_occurrences,
   input  logic                                     csr_write_en,
   input  logic [bpfc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bpfc_pkg::LEN_BITS-1:0]            csr_wdata
);
   import bpfc_pkg::*;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                  op_ff;
   logic [LEN_BITS-1:0]   qlen_ff;
   logic [LEN_BITS-1:0]   min_len_ff, max_len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic [COUNT_BITS-1:0] sel_count;
   cell_ctrl_type         ctrl;

   logic [LONGEST_PATTERN-1:0] window;
   logic [LONGEST_PATTERN-1:0] fill_vec;
   logic [LONGEST_PATTERN-1:0] next_window;
   logic [LONGEST_PATTERN-1:0] next_fill;
   logic [LONGEST_PATTERN-2:0] fill_gaps;
   logic [COUNT_BITS-1:0]      cell_count [LONGEST_PATTERN];

   // Transactions are taken only in the idle state; each one owns the cells until the
   // sequencer returns to idle.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A read transaction delivers its count once the output register is free or
   // being emptied in the same cycle.
   assign rsp_load = (state_ff == ST_UPDATE) && (op_ff == ACTION_READ) &&
                     (!rsp_valid_ff || !rsp_stall);

   // The window shifts toward higher bit positions; bit 0 is the newest bit.
   // The fill flags shift the same way with a constant one entering, forming a
   // thermometer code of how many bits have arrived.
   assign next_window = {window[LONGEST_PATTERN-2:0], req_stream_bit};
   assign next_fill   = {fill_vec[LONGEST_PATTERN-2:0], 1'b1};

   // A set flag above a clear one would break the thermometer code.
   assign fill_gaps = fill_vec[LONGEST_PATTERN-1:1] & ~fill_vec[LONGEST_PATTERN-2:0];

   always_comb begin
      ctrl            = '0;
      ctrl.lookup     = req_accept;
      ctrl.shift      = req_accept && (req_action == ACTION_SHIFT);
      ctrl.update     = (state_ff == ST_UPDATE) && (op_ff == ACTION_SHIFT);
      ctrl.clear      = (state_ff == ST_CLEAR);
      ctrl.clear_addr = clr_cnt_ff;
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_BITS'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (op_ff == ACTION_SHIFT || rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Pick the counter of the queried length; lengths outside the chain read zero.
   always_comb begin
      sel_count = '0;
      for (int i = 0; i < LONGEST_PATTERN; i++) begin
         if (qlen_ff == LEN_BITS'(i + 1)) begin
            sel_count = cell_count[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         min_len_ff   <= LEN_BITS'(1);
         max_len_ff   <= LEN_BITS'(LONGEST_PATTERN);
         op_ff        <= ACTION_SHIFT;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            op_ff <= req_action;
         end
         if (csr_write_en) begin
            if (csr_index == CSR_MIN_LENGTH) begin
               min_len_ff <= csr_wdata;
            end else if (csr_index == CSR_MAX_LENGTH) begin
               max_len_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         qlen_ff <= req_query_length;
      end
      if (rsp_load) begin
         rsp_count_ff <= sel_count;
      end
   end

   for (genvar i = 0; i < LONGEST_PATTERN; i++) begin : g_cell
      bpfc_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .cell_len      (LEN_BITS'(i + 1)),
         .min_length    (min_len_ff),
         .max_length    (max_len_ff),
         .bit_in        (next_window[i]),
         .fill_in       (next_fill[i]),
         .next_window   (next_window),
         .query_pattern (req_query_pattern),
         .bit_out       (window[i]),
         .fill_out      (fill_vec[i]),
         .count_out     (cell_count[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_occurrences = rsp_count_ff;

   // A read that finds the output register free must present its response next cycle.
   `BPFC_ASSERT_NEXT(a_read_delivers, clock, reset, rsp_load, rsp_valid_ff)
   // The fill flags form a thermometer code starting at the newest bit.
   `BPFC_ASSERT_IMPL(a_fill_thermo, clock, reset, 1'b1, fill_gaps == '0)
   // Once the whole window has been filled it stays filled until reset.
   `BPFC_ASSERT_NEXT(a_fill_sticky, clock, reset, fill_vec[LONGEST_PATTERN-1], fill_vec[LONGEST_PATTERN-1])
   // Counter write-back happens only for a shift transaction accepted the cycle before.
   `BPFC_ASSERT_IMPL(a_update_after_shift, clock, reset, ctrl.update, $past(ctrl.shift))

endmodule

// ===== design/bpfc_cell.sv =====
// One cell of the counter chain: one window bit, one fill flag and the counter bank
// for a single pattern length. Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bpfc_pkg::cell_ctrl_type                  ctrl,
   input  logic [bpfc_pkg::LEN_BITS-1:0]            cell_len,
   input  logic [bpfc_pkg::LEN_BITS-1:0]            min_length,
   input  logic [bpfc_pkg::LEN_BITS-1:0]            max_length,
   input  logic                                     bit_in,
   input  logic                                     fill_in,
   input  logic [bpfc_pkg::ADDR_BITS-1:0]           next_window,
   input  logic [bpfc_pkg::ADDR_BITS-1:0]           query_pattern,
   output logic                                     bit_out,
   output logic                                     fill_out,
   output logic [bpfc_pkg::COUNT_BITS-1:0]          count_out
);
   import bpfc_pkg::*;

   logic                  bit_ff;
   logic                  fill_ff;
   logic                  active_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [COUNT_BITS-1:0] rd_ff;
   logic [COUNT_BITS-1:0] bank [PATTERN_SPACE];

   logic [ADDR_BITS-1:0]  addr_in;
   logic                  active_in;
   logic [COUNT_BITS-1:0] count_inc;

   // The pattern is the newest cell_len window bits after a shift, else the query.
   assign addr_in   = (ctrl.shift ? next_window : query_pattern) & low_mask(cell_len);
   assign active_in = ctrl.shift && fill_in &&
                      (cell_len >= min_length) && (cell_len <= max_length);
   assign count_inc = (rd_ff == COUNT_MAX) ? rd_ff : rd_ff + COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff    <= 1'b0;
         fill_ff   <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         if (ctrl.shift) begin
            bit_ff  <= bit_in;
            fill_ff <= fill_in;
         end
         if (ctrl.lookup) begin
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         addr_ff <= addr_in;
         rd_ff   <= bank[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         bank[ctrl.clear_addr] <= '0;
      end else if (ctrl.update && active_ff) begin
         bank[addr_ff] <= count_inc;
      end
   end

   assign bit_out   = bit_ff;
   assign fill_out  = fill_ff;
   assign count_out = rd_ff;

endmodule
